/* hw/rtl/svr_pkg.sv */
// Shared types and constants for the vector refraction pipeline.
// No dependencies; used by svr_div, svr_isqrt and snell_vector_refraction.
package svr_pkg;

	localparam int DIV_STAGES  = 16;	// two quotient bits per stage
	localparam int SQRT_STAGES = 16;	// two root bits per stage

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic [17:0]        index_before;
		logic [17:0]        index_after;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
	} ray_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               internal_reflection;
	} ray_out_t;

endpackage

/* hw/rtl/svr_div.sv */
// Pipelined restoring divider: ratio = (dividend << 30) / divisor, Q2.30, saturated.
// Depends on svr_pkg for the stage count.
module svr_div (
	input  logic        clk,
	input  logic        en,
	input  logic [17:0] dividend,
	input  logic [17:0] divisor,
	output logic [31:0] quotient
);
	import svr_pkg::*;

	logic [17:0] rem_s [DIV_STAGES];
	logic [31:0] quo_s [DIV_STAGES];
	logic [31:0] dvd_s [DIV_STAGES];
	logic [17:0] dsr_s [DIV_STAGES];
	logic        sat_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [17:0] r_in, r_out;
		logic [31:0] q_in, q_out, x_in;
		logic [17:0] d_in;
		logic        s_in;

		if (k == 0) begin : g_first
			// quotient >= 2^32 exactly when dividend >= 4 * divisor
			assign r_in = {2'b00, dividend[17:2]};
			assign q_in = '0;
			assign x_in = {dividend[1:0], 30'b0};
			assign d_in = divisor;
			assign s_in = ({2'b00, dividend} >= {divisor, 2'b00});
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign x_in = dvd_s[k-1];
			assign d_in = dsr_s[k-1];
			assign s_in = sat_s[k-1];
		end

		always_comb begin
			logic [18:0] r;
			logic [17:0] rr;
			logic        ge;
			rr    = r_in;
			q_out = q_in;
			for (int j = 0; j < 2; j++) begin
				r  = {rr, x_in[31-j]};
				ge = (r >= {1'b0, d_in});
				rr = ge ? 18'(r - {1'b0, d_in}) : r[17:0];
				q_out = {q_out[30:0], ge};
			end
			r_out = rr;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_out;
				quo_s[k] <= q_out;
				dvd_s[k] <= {x_in[29:0], 2'b00};
				dsr_s[k] <= d_in;
				sat_s[k] <= s_in;
			end
		end
	end

	assign quotient = sat_s[DIV_STAGES-1] ? 32'hFFFF_FFFF : quo_s[DIV_STAGES-1];

endmodule

/* hw/rtl/svr_isqrt.sv */
// Pipelined digit-by-digit integer square root, floor(sqrt(radicand)).
// Depends on svr_pkg for the stage count.
module svr_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] radicand,
	output logic [30:0] root
);
	import svr_pkg::*;

	logic [33:0] rem_s [SQRT_STAGES];
	logic [31:0] rt_s  [SQRT_STAGES];
	logic [63:0] x_s   [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [33:0] r_in, r_out;
		logic [31:0] t_in, t_out;
		logic [63:0] x_in;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign t_in = '0;
			assign x_in = {3'b000, radicand};
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign t_in = rt_s[k-1];
			assign x_in = x_s[k-1];
		end

		always_comb begin
			logic [35:0] r, trial;
			logic [33:0] rr;
			logic        ge;
			rr    = r_in;
			t_out = t_in;
			for (int j = 0; j < 2; j++) begin
				r     = {rr, x_in[63-2*j -: 2]};
				trial = {2'b00, t_out, 2'b01};
				ge    = (r >= trial);
				rr    = ge ? 34'(r - trial) : r[33:0];
				t_out = {t_out[30:0], ge};
			end
			r_out = rr;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_out;
				rt_s[k]  <= t_out;
				x_s[k]   <= {x_in[59:0], 4'b0000};
			end
		end
	end

	assign root = rt_s[SQRT_STAGES-1][30:0];

endmodule

/* hw/rtl/snell_vector_refraction.sv */
// Vector Snell refraction of one ray per item, Q1.30 directions, Q2.16 indices.
// Depends on svr_pkg, svr_div and svr_isqrt.
//
//   channel | valid     | stall     | payload
//   input   | ray_valid | ray_stall | ray (ray_in_t)
//   output  | res_valid | res_stall | res (ray_out_t)
//
// One item per cycle while the output is not stalled; the divider and square root
// pipelines each resolve two bits per stage.
// Reset clears only the valid bits; no item is held after reset.
// A stall on a valid output freezes the whole pipe and is passed back to the input.
module snell_vector_refraction (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ray_valid,
	output logic             ray_stall,
	input  svr_pkg::ray_in_t ray,
	output logic             res_valid,
	input  logic             res_stall,
	output svr_pkg::ray_out_t res
);
	import svr_pkg::*;

	localparam int LAT = DIV_STAGES + SQRT_STAGES + 11;
	localparam int S24 = DIV_STAGES + 7;

	typedef logic signed [31:0] vec_t [3];

	typedef struct packed {
		logic signed [2:0][31:0] d;
		logic signed [2:0][31:0] n;
		logic                    eq;
	} side1_t;

	typedef struct packed {
		logic signed [2:0][31:0] d;
		logic signed [2:0][31:0] n;
		logic [31:0]             ratio;
		logic [33:0]             rcr;
		logic                    eq;
		logic                    tir;
	} side2_t;

	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv       = !(vld_q[LAT-1] && res_stall);
	assign ray_stall = !adv;
	assign res_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], ray_valid};
		end
	end

	// ---- divider, side data delayed alongside ----
	logic [31:0] ratio_div;
	side1_t      sd1_s [DIV_STAGES];

	svr_div u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (ray.index_before),
		.divisor  (ray.index_after),
		.quotient (ratio_div)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sd1_s[0].d  <= {ray.dir_z, ray.dir_y, ray.dir_x};
			sd1_s[0].n  <= {ray.normal_z, ray.normal_y, ray.normal_x};
			sd1_s[0].eq <= (ray.index_before == ray.index_after);
			for (int k = 1; k < DIV_STAGES; k++) sd1_s[k] <= sd1_s[k-1];
		end
	end

	// ---- cosine and radicand chain ----
	logic [31:0]        ratio_s17, ratio_s18, ratio_s19, ratio_s20, ratio_s21, ratio_s22;
	logic [31:0]        ratio_s23, ratio_s24;
	logic signed [63:0] prod_s17 [3];
	side1_t             sd_s17, sd_s18, sd_s19, sd_s20, sd_s21, sd_s22, sd_s23, sd_s24;
	logic [30:0]        cosi_s18;
	logic [61:0]        csq_s19;
	logic [62:0]        rc_s19, s1p_s21;
	logic [30:0]        sin2_s20;
	logic [33:0]        rcr_s20, rcr_s21, rcr_s22, rcr_s23, rcr_s24;
	logic [32:0]        s1_s22;
	logic [64:0]        tp_s23;
	logic [30:0]        rad_s24;
	logic               tir_s24;

	logic [30:0] cosi_c;
	logic [30:0] sin2_c;
	logic [33:0] rcr_c;
	logic [32:0] s1_c;
	logic [30:0] rad_c;
	logic        tir_c;

	always_comb begin
		logic signed [63:0] t;
		logic signed [35:0] dot, mag;
		dot = '0;
		for (int i = 0; i < 3; i++) begin
			t   = prod_s17[i] + 64'sd536870912;
			dot = dot + 36'(t >>> 30);
		end
		mag    = (dot < 0) ? -dot : dot;
		cosi_c = (mag > 36'sd1073741824) ? ONE_Q30 : mag[30:0];
	end

	always_comb begin
		logic [62:0] c2;
		logic [63:0] rr;
		c2     = {1'b0, csq_s19} + 63'd536870912;
		// cosi^2 rounded, clamped to one
		sin2_c = (c2[62:30] >= 33'd1073741824) ? '0 : 31'(ONE_Q30 - c2[60:30]);
		rr     = {1'b0, rc_s19} + 64'd536870912;
		rcr_c  = rr[63:30];
	end

	always_comb begin
		logic [63:0] a;
		a    = {1'b0, s1p_s21} + 64'd536870912;
		s1_c = a[62:30];
	end

	always_comb begin
		logic [65:0] a;
		logic [35:0] t;
		a     = {1'b0, tp_s23} + 66'd536870912;
		t     = a[65:30];
		tir_c = (t > 36'd1073741824);
		rad_c = tir_c ? '0 : 31'(36'd1073741824 - t);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ratio_s17 <= ratio_div;
			sd_s17    <= sd1_s[DIV_STAGES-1];
			for (int i = 0; i < 3; i++)
				prod_s17[i] <= $signed(sd1_s[DIV_STAGES-1].d[i])
					* $signed(sd1_s[DIV_STAGES-1].n[i]);

			ratio_s18 <= ratio_s17;
			sd_s18    <= sd_s17;
			cosi_s18  <= cosi_c;

			ratio_s19 <= ratio_s18;
			sd_s19    <= sd_s18;
			csq_s19   <= cosi_s18 * cosi_s18;
			rc_s19    <= ratio_s18 * cosi_s18;

			ratio_s20 <= ratio_s19;
			sd_s20    <= sd_s19;
			sin2_s20  <= sin2_c;
			rcr_s20   <= rcr_c;

			ratio_s21 <= ratio_s20;
			sd_s21    <= sd_s20;
			rcr_s21   <= rcr_s20;
			s1p_s21   <= sin2_s20 * ratio_s20;

			ratio_s22 <= ratio_s21;
			sd_s22    <= sd_s21;
			rcr_s22   <= rcr_s21;
			s1_s22    <= s1_c;

			ratio_s23 <= ratio_s22;
			sd_s23    <= sd_s22;
			rcr_s23   <= rcr_s22;
			tp_s23    <= s1_s22 * ratio_s22;

			ratio_s24 <= ratio_s23;
			sd_s24    <= sd_s23;
			rcr_s24   <= rcr_s23;
			rad_s24   <= rad_c;
			tir_s24   <= tir_c;
		end
	end

	// ---- square root, side data delayed alongside ----
	logic [30:0] cosr;
	side2_t      sd2_s [SQRT_STAGES];

	svr_isqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand ({rad_s24, 30'b0}),
		.root     (cosr)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sd2_s[0].d     <= sd_s24.d;
			sd2_s[0].n     <= sd_s24.n;
			sd2_s[0].eq    <= sd_s24.eq;
			sd2_s[0].ratio <= ratio_s24;
			sd2_s[0].rcr   <= rcr_s24;
			sd2_s[0].tir   <= tir_s24;
			for (int k = 1; k < SQRT_STAGES; k++) sd2_s[k] <= sd2_s[k-1];
		end
	end

	// ---- output direction ----
	side2_t             sd_s41, sd_s42;
	logic signed [34:0] gamma_s41;
	logic signed [64:0] rd_s41 [3];
	logic signed [66:0] g_s42  [3];
	logic signed [34:0] rdr_s42 [3];
	ray_out_t           res_s43;

	logic signed [34:0] rdr_c [3];
	ray_out_t           res_c;

	always_comb begin
		logic signed [64:0] t;
		for (int i = 0; i < 3; i++) begin
			t        = rd_s41[i] + 65'sd536870912;
			rdr_c[i] = 35'(t >>> 30);
		end
	end

	always_comb begin
		logic signed [66:0] t;
		logic signed [37:0] s;
		vec_t               o;
		for (int i = 0; i < 3; i++) begin
			t = g_s42[i] + 67'sd536870912;
			s = 38'(t >>> 30) + 38'(rdr_s42[i]);
			if (sd_s42.eq || sd_s42.tir)
				o[i] = sd_s42.d[i];
			else if (s > 38'sd1073741824)
				o[i] = 32'sd1073741824;
			else if (s < -38'sd1073741824)
				o[i] = -32'sd1073741824;
			else
				o[i] = s[31:0];
		end
		res_c.out_x               = o[0];
		res_c.out_y               = o[1];
		res_c.out_z               = o[2];
		res_c.internal_reflection = !sd_s42.eq && sd_s42.tir;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s41    <= sd2_s[SQRT_STAGES-1];
			gamma_s41 <= $signed({1'b0, sd2_s[SQRT_STAGES-1].rcr}) - $signed({4'b0, cosr});
			for (int i = 0; i < 3; i++)
				rd_s41[i] <= $signed({1'b0, sd2_s[SQRT_STAGES-1].ratio})
					* $signed(sd2_s[SQRT_STAGES-1].d[i]);

			sd_s42 <= sd_s41;
			for (int i = 0; i < 3; i++) begin
				g_s42[i]   <= gamma_s41 * $signed(sd_s41.n[i]);
				rdr_s42[i] <= rdr_c[i];
			end

			res_s43 <= res_c;
		end
	end

	assign res = res_s43;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall |-> res_valid)
		else $error("input stalled with no item waiting at the output");

	a_tir_zero_rad: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[S24] && tir_s24) |-> (rad_s24 == '0))
		else $error("radicand not cleared on internal reflection");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");
`endif

endmodule
